// File: design/assert_macros.svh
// Assertion macros for the design file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dft_pkg.sv
// Package with the sizes, types and helper functions of the fingerprint table.
package dft_pkg;

  localparam int BUCKETS  = 256;
  localparam int WAYS     = 4;
  localparam int CRC_BITS = 32;

  localparam int IN_BKT_W = 8;
  localparam int IN_CRC_W = 32;
  localparam int ADDR_W   = 64;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CRC_W = (CRC_BITS < IN_CRC_W) ? CRC_BITS : IN_CRC_W;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  typedef struct packed {
    logic              valid;
    logic [CRC_W-1:0]  crc;
    logic [ADDR_W-1:0] addr;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [WAY_W-1:0]  free_way;
    logic [ADDR_W-1:0] hit_addr;
  } match_t;

  // Reduces the incoming bucket number modulo BUCKETS by restoring subtraction.
  function automatic logic [BKT_W-1:0] bucket_index(input logic [IN_BKT_W-1:0] b);
    logic [IN_BKT_W-1:0] r;
    r = b;
    for (int k = IN_BKT_W - 1; k >= 0; k--) begin
      if ((BUCKETS << k) < (1 << IN_BKT_W)) begin
        if (r >= IN_BKT_W'(BUCKETS << k)) begin
          r = r - IN_BKT_W'(BUCKETS << k);
        end
      end
    end
    return BKT_W'(r);
  endfunction

endpackage

// File: design/dft_stream_if.sv
// Valid/ready channel interfaces for the request and result items.
interface dft_in_if import dft_pkg::*;;
  logic                valid;
  logic                ready;
  logic                func;
  logic [IN_BKT_W-1:0] bucket;
  logic [IN_CRC_W-1:0] crc;
  logic [ADDR_W-1:0]   block_addr;

  modport source (output valid, func, bucket, crc, block_addr, input ready);
  modport sink (input valid, func, bucket, crc, block_addr, output ready);
endinterface

interface dft_out_if import dft_pkg::*;;
  logic              valid;
  logic              ready;
  logic              unique_res;
  logic [ADDR_W-1:0] match_addr;
  logic              status;

  modport source (output valid, unique_res, match_addr, status, input ready);
  modport sink (input valid, unique_res, match_addr, status, output ready);
endinterface

// File: design/dft_row_mem.sv
// Bucket row memory: one write port and one registered read port.
module dft_row_mem import dft_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [BKT_W-1:0] waddr,
  input  row_t             wdata,
  input  logic             re,
  input  logic [BKT_W-1:0] raddr,
  output row_t             rdata
);

  row_t mem [BUCKETS];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/dft_bucket_match.sv
// Searches one bucket row for a matching fingerprint and for the first free way.
module dft_bucket_match import dft_pkg::*; (
  input  row_t             row,
  input  logic [CRC_W-1:0] crc,
  output match_t           mres
);

  logic free_seen;

  always_comb begin
    mres      = '0;
    free_seen = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if ((row[w].crc == crc) && !mres.hit) begin
          mres.hit      = 1'b1;
          mres.hit_addr = row[w].addr;
        end
      end else if (!free_seen) begin
        free_seen     = 1'b1;
        mres.free_way = WAY_W'(w);
      end
    end
    mres.full = !free_seen;
  end

endmodule

// File: design/dedup_fingerprint_table.sv
// Top level of the deduplication fingerprint table.
// The block keeps BUCKETS buckets of WAYS entries, one bucket per memory row.
// Requests arrive on in_chan (valid/ready). An add item reads the bucket row,
// compares all ways at once and, on a miss with a free way, writes the row back.
// Every item yields exactly one result item on out_chan (valid/ready).
// An add item passes through the registered row read, then the compare and
// write-back in S_CHECK, which waits until the output register frees up.
// The result is written into the output register from S_CHECK.
// A clear item sweeps all rows, one per cycle, and then delivers its result
// from S_FINISH once the output register frees up.
// After reset the block runs the same sweep over all rows and holds
// in_chan.ready low until it is done.
// The output register lets a new item be accepted while a result still waits.
// If the receiver stalls, a finished item waits in S_CHECK or S_FINISH and no
// further item is accepted until the output register frees up.
`include "assert_macros.svh"

module dedup_fingerprint_table import dft_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  dft_in_if.sink    in_chan,
  dft_out_if.source out_chan
);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_CHECK, S_CLEAR, S_FINISH} state_t;

  state_t            state_r, state_nxt;
  logic [BKT_W-1:0]  cnt_r, cnt_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_unique_r, out_unique_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_status_r, out_status_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              mem_we;
  logic [BKT_W-1:0]  mem_waddr;
  row_t              mem_wdata;
  logic              mem_re;
  logic [BKT_W-1:0]  mem_raddr;
  row_t              rd_row;
  row_t              upd_row;
  match_t            mres;

  dft_row_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_row)
  );

  dft_bucket_match u_match (
    .row  (rd_row),
    .crc  (crc_r),
    .mres (mres)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  always_comb begin
    upd_row                     = rd_row;
    upd_row[mres.free_way]      = '0;
    upd_row[mres.free_way].valid = 1'b1;
    upd_row[mres.free_way].crc  = crc_r;
    upd_row[mres.free_way].addr = addr_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    bkt_nxt        = bkt_r;
    crc_nxt        = crc_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_unique_nxt = out_unique_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = bucket_index(in_chan.bucket);
    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        if (cnt_r == BKT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == FUNC_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end else begin
            mem_re    = 1'b1;
            bkt_nxt   = mem_raddr;
            crc_nxt   = in_chan.crc[CRC_W-1:0];
            addr_nxt  = in_chan.block_addr;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_unique_nxt = !mres.hit;
          out_addr_nxt   = mres.hit ? mres.hit_addr : addr_r;
          out_status_nxt = !mres.hit && mres.full;
          if (!mres.hit && !mres.full) begin
            mem_we    = 1'b1;
            mem_waddr = bkt_r;
            mem_wdata = upd_row;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == BKT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_unique_nxt = 1'b0;
          out_addr_nxt   = '0;
          out_status_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bkt_r        <= bkt_nxt;
    crc_r        <= crc_nxt;
    addr_r       <= addr_nxt;
    out_unique_r <= out_unique_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.unique_res = out_unique_r;
  assign out_chan.match_addr = out_addr_r;
  assign out_chan.status     = out_status_r;

  `DFT_ASSERT_NEXT(a_add_goes_to_check, in_acc && (in_chan.func == FUNC_ADD), state_r == S_CHECK, "add item did not move to the check stage")
  `DFT_ASSERT_NOW(a_write_only_on_miss, mem_we && (state_r == S_CHECK), !mres.hit && !mres.full, "row written back on a hit or a full bucket")
  `DFT_ASSERT_NOW(a_full_is_unique, out_chan.valid && out_chan.status, out_chan.unique_res, "full status reported on a duplicate")

endmodule
